[hdl/lspt_pkg.sv]
package lspt_pkg;

    localparam int NCH            = 5;
    localparam int AVG_COUNT_DEF  = 8;
    localparam int BAT_COUNT_DEF  = 64;
    localparam int NORM_BITS_DEF  = 12;
    localparam int COEF_SHIFT_DEF = 8;
    localparam int COEF_W         = 21;
    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
    localparam logic [11:0] LIN_MAX = 12'd4095;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_FLAG_SET   = 2'd0;
    localparam logic [1:0] REG_FLAG_CLEAR = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE   = 2'd2;
    localparam logic [1:0] REG_BAT_LOW    = 2'd3;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_SCAN    = 2'd0;
    localparam logic [1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [1:0] FUNC_MINMAX  = 2'd2;
    localparam logic [1:0] FUNC_COEF    = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] sample_0;
        logic [11:0] sample_1;
        logic [11:0] sample_2;
        logic [11:0] sample_3;
        logic [11:0] sample_4;
        logic [11:0] battery_sample;
    } t_in_word;

    typedef struct packed {
        logic [9:0]  position;
        logic        position_valid;
        logic [4:0]  sensor_flags;
        logic [11:0] battery_average;
        logic        battery_valid;
        logic        battery_low;
    } t_out_word;

    // Control handed to the serial divider.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHAN,
        ST_MUL,
        ST_POS_DIV,
        ST_POS_WAIT,
        ST_FLAGS,
        ST_COEF_DIV,
        ST_COEF_WAIT,
        ST_OUT
    } t_state;

    function automatic logic [9:0] weight_of(input logic [2:0] ch);
        logic [9:0] w;
        case (ch)
            3'd0: w = 10'd166;
            3'd1: w = 10'd333;
            3'd2: w = 10'd500;
            3'd3: w = 10'd666;
            3'd4: w = 10'd833;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

endpackage

[hdl/lspt_div.sv]
// Restoring divider, one quotient bit per cycle.
module lspt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lspt_pkg::t_div_req i_req,
    output lspt_pkg::t_div_rsp o_rsp
);
    import lspt_pkg::*;

    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    // One shift-subtract step a cycle.
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

[hdl/line_sensor_position_tracker.sv]
// Line-sensor position tracker.
// Input channel: i_in_valid / o_in_stall carry one word of func, five sensor
// samples and a battery sample. Output channel: o_out_valid / i_out_stall
// carry one result word for every input word.
// A scan word adds the samples into per-channel sums. Every AVG_COUNT scans
// the channels are averaged, calibrated and scaled one at a time, and the
// weighted centroid is taken by a serial divider. For a coefficient compute
// word the divider runs once for each channel whose maximum is above its
// minimum.
// The block works on one word at a time; o_in_stall is high from acceptance
// until that word's result is loaded into the output register. While
// i_out_stall holds a result word, the next word is still taken and worked
// on, and it waits in its last step until the output register is free.
// Reset (synchronous, i_rst_n low) clears all sums and counters, sets the
// calibration to minimum 0 and maximum 65535 and restores register defaults.
// Configuration writes through i_cfg_we / i_cfg_idx / i_cfg_data take effect
// at once. They are made only while the block is idle; the user keeps to this, the block has no guard for it.
module line_sensor_position_tracker #(
    parameter int AVG_COUNT  = lspt_pkg::AVG_COUNT_DEF,
    parameter int BAT_COUNT  = lspt_pkg::BAT_COUNT_DEF,
    parameter int NORM_BITS  = lspt_pkg::NORM_BITS_DEF,
    parameter int COEF_SHIFT = lspt_pkg::COEF_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lspt_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lspt_pkg::t_out_word o_out_data
);
    import lspt_pkg::*;

    localparam int AVG_W  = $clog2(AVG_COUNT + 1);
    localparam int BAT_W  = $clog2(BAT_COUNT + 1);
    localparam int SUM_W  = 12 + $clog2(AVG_COUNT + 1);
    localparam int BSUM_W = 12 + $clog2(BAT_COUNT + 1);
    localparam logic [31:0] COEF_NUM = 32'd1 << (NORM_BITS + COEF_SHIFT);
    localparam logic [COEF_W-1:0] COEF_RST =
        COEF_W'((64'd1 << (NORM_BITS + COEF_SHIFT)) / 64'd65535);

    // Configuration registers.
    logic [12:0] r_set_lvl, r_clr_lvl;
    logic [7:0]  r_debounce;
    logic [11:0] r_bat_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_lvl  <= 13'd2048;
            r_clr_lvl  <= 13'd1024;
            r_debounce <= 8'd10;
            r_bat_low  <= 12'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FLAG_SET:   r_set_lvl  <= i_cfg_data;
                REG_FLAG_CLEAR: r_clr_lvl  <= i_cfg_data;
                REG_DEBOUNCE:   r_debounce <= i_cfg_data[7:0];
                REG_BAT_LOW:    r_bat_low  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Working state.
    t_state              r_st, n_st;
    t_in_word            r_in;
    logic [SUM_W-1:0]    r_sum [NCH];
    logic [11:0]         r_avg [NCH];
    logic [15:0]         r_min [NCH];
    logic [15:0]         r_max [NCH];
    logic [COEF_W-1:0]   r_coef [NCH];
    logic [12:0]         r_inv [NCH];
    logic [AVG_W-1:0]    r_scan_cnt;
    logic [BSUM_W-1:0]   r_bsum;
    logic [BAT_W-1:0]    r_bat_cnt;
    logic [11:0]         r_bat_avg;
    logic [4:0]          r_flags, r_last_flags;
    logic [7:0]          r_lost;
    logic [9:0]          r_last_pos;
    logic [2:0]          r_ch;
    logic [32:0]         r_prod;
    logic [23:0]         r_num;
    logic [15:0]         r_den;
    logic [9:0]          r_pos;
    logic                r_pvalid, r_bvalid;
    t_out_word           r_out;
    logic                r_out_valid;

    t_div_req            w_req;
    t_div_rsp            w_rsp;

    lspt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    logic        w_in_acc, w_out_acc, w_out_load;
    logic [11:0] w_samp [NCH];
    logic [11:0] w_cavg;
    logic [11:0] w_lin;
    logic [12:0] w_inv;
    logic [15:0] w_span;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_out_load = (r_st == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_st != ST_IDLE);

    assign w_samp[0] = r_in.sample_0;
    assign w_samp[1] = r_in.sample_1;
    assign w_samp[2] = r_in.sample_2;
    assign w_samp[3] = r_in.sample_3;
    assign w_samp[4] = r_in.sample_4;

    // Channel average of the channel under work, and its scaled level.
    always_comb begin
        w_cavg = 12'((r_sum[r_ch] / SUM_W'(AVG_COUNT)));
        if ((|r_prod[32:COEF_SHIFT+12]) || (r_prod[COEF_SHIFT+11:COEF_SHIFT] > LIN_MAX))
            w_lin = LIN_MAX;
        else
            w_lin = r_prod[COEF_SHIFT+11:COEF_SHIFT];
        w_inv  = 13'd4096 - {1'b0, w_lin};
        w_span = r_max[r_ch] - r_min[r_ch];
    end

    // Sequencer next state and divider request.
    always_comb begin
        n_st = r_st;
        w_req.start = 1'b0;
        w_req.num   = COEF_NUM;
        w_req.den   = {16'd0, w_span};
        case (r_st)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.func == FUNC_SCAN)      n_st = ST_ACC;
                    else if (i_in_data.func == FUNC_COEF) n_st = ST_COEF_DIV;
                    else                                  n_st = ST_OUT;
                end
            end
            ST_ACC: begin
                if (r_scan_cnt + AVG_W'(1) >= AVG_W'(AVG_COUNT)) n_st = ST_CHAN;
                else n_st = ST_OUT;
            end
            ST_CHAN:  n_st = ST_MUL;
            ST_MUL: begin
                if (r_ch == 3'(NCH - 1)) n_st = ST_POS_DIV;
                else n_st = ST_CHAN;
            end
            ST_POS_DIV: begin
                w_req.start = 1'b1;
                w_req.num   = {8'd0, r_num};
                w_req.den   = {16'd0, r_den};
                n_st = ST_POS_WAIT;
            end
            ST_POS_WAIT: if (w_rsp.done) n_st = ST_FLAGS;
            ST_FLAGS: n_st = ST_OUT;
            ST_COEF_DIV: begin
                w_req.start = (r_max[r_ch] > r_min[r_ch]);
                n_st = (r_max[r_ch] > r_min[r_ch]) ? ST_COEF_WAIT : ST_COEF_DIV;
                if (!(r_max[r_ch] > r_min[r_ch]) && r_ch == 3'(NCH - 1)) n_st = ST_OUT;
            end
            ST_COEF_WAIT: begin
                if (w_rsp.done) n_st = (r_ch == 3'(NCH - 1)) ? ST_OUT : ST_COEF_DIV;
            end
            ST_OUT:   if (w_out_load) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_sum[i]  <= '0;
                r_avg[i]  <= '0;
                r_min[i]  <= 16'd0;
                r_max[i]  <= 16'hFFFF;
                r_coef[i] <= COEF_RST;
            end
            r_scan_cnt   <= '0;
            r_bsum       <= '0;
            r_bat_cnt    <= '0;
            r_bat_avg    <= '0;
            r_flags      <= '0;
            r_last_flags <= '0;
            r_lost       <= '0;
            r_last_pos   <= '0;
            r_ch         <= '0;
            r_pvalid     <= 1'b0;
            r_bvalid     <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    r_ch     <= '0;
                    r_num    <= '0;
                    r_den    <= '0;
                    r_pos    <= '0;
                    r_pvalid <= 1'b0;
                    r_bvalid <= 1'b0;
                    if (w_in_acc) begin
                        r_in <= i_in_data;
                        if (i_in_data.func == FUNC_CLEAR) begin
                            for (int i = 0; i < NCH; i++) begin
                                r_min[i] <= 16'hFFFF;
                                r_max[i] <= 16'd0;
                            end
                        end else if (i_in_data.func == FUNC_MINMAX) begin
                            for (int i = 0; i < NCH; i++) begin
                                if ({4'd0, r_avg[i]} < r_min[i]) r_min[i] <= {4'd0, r_avg[i]};
                                if ({4'd0, r_avg[i]} > r_max[i]) r_max[i] <= {4'd0, r_avg[i]};
                            end
                        end
                    end
                end
                ST_ACC: begin
                    for (int i = 0; i < NCH; i++)
                        r_sum[i] <= r_sum[i] + SUM_W'(w_samp[i]);
                    if (r_scan_cnt + AVG_W'(1) >= AVG_W'(AVG_COUNT)) begin
                        r_scan_cnt <= '0;
                        r_pvalid   <= 1'b1;
                    end else begin
                        r_scan_cnt <= r_scan_cnt + AVG_W'(1);
                    end
                    if (r_bat_cnt + BAT_W'(1) >= BAT_W'(BAT_COUNT)) begin
                        r_bat_avg <= 12'((r_bsum + BSUM_W'(r_in.battery_sample))
                                         / BSUM_W'(BAT_COUNT));
                        r_bsum    <= '0;
                        r_bat_cnt <= '0;
                        r_bvalid  <= 1'b1;
                    end else begin
                        r_bsum    <= r_bsum + BSUM_W'(r_in.battery_sample);
                        r_bat_cnt <= r_bat_cnt + BAT_W'(1);
                    end
                end
                ST_CHAN: begin
                    // Average, remove minimum, multiply by coefficient.
                    r_avg[r_ch] <= w_cavg;
                    r_sum[r_ch] <= '0;
                    if ({4'd0, w_cavg} > r_min[r_ch])
                        r_prod <= 33'({4'd0, w_cavg} - r_min[r_ch]) * 33'(r_coef[r_ch]);
                    else
                        r_prod <= '0;
                end
                ST_MUL: begin
                    r_inv[r_ch] <= w_inv;
                    r_num <= r_num + 24'(w_inv) * 24'(weight_of(r_ch));
                    r_den <= r_den + 16'(w_inv);
                    r_ch  <= r_ch + 3'd1;
                end
                ST_POS_WAIT: if (w_rsp.done) r_pos <= w_rsp.quo[9:0];
                ST_FLAGS: begin
                    logic [4:0] v_fl;
                    v_fl = r_flags;
                    for (int i = 0; i < NCH; i++) begin
                        if (r_inv[i] > r_set_lvl)      v_fl[i] = 1'b1;
                        else if (r_inv[i] < r_clr_lvl) v_fl[i] = 1'b0;
                    end
                    r_flags <= v_fl;
                    if (v_fl != 5'd0) begin
                        if (r_lost != 8'd0) r_lost <= 8'd0;
                        else begin
                            r_last_pos   <= r_pos;
                            r_last_flags <= v_fl;
                        end
                    end else if (r_lost < r_debounce) begin
                        r_lost <= r_lost + 8'd1;
                    end else if (r_last_pos >= 10'd500) begin
                        r_pos <= r_last_flags[0] ? 10'd1 : 10'd1000;
                    end else begin
                        r_pos <= r_last_flags[4] ? 10'd1000 : 10'd1;
                    end
                end
                ST_COEF_DIV: begin
                    if (r_max[r_ch] == r_min[r_ch]) r_coef[r_ch] <= COEF_MAX;
                    else if (r_max[r_ch] < r_min[r_ch]) r_coef[r_ch] <= '0;
                    if (!(r_max[r_ch] > r_min[r_ch])) r_ch <= r_ch + 3'd1;
                end
                ST_COEF_WAIT: begin
                    if (w_rsp.done) begin
                        r_coef[r_ch] <= (|w_rsp.quo[31:COEF_W]) ? COEF_MAX
                                                                 : w_rsp.quo[COEF_W-1:0];
                        r_ch <= r_ch + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register; holds while the receiver stalls and is reloaded
    // once the waiting word has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out.position        <= r_pvalid ? r_pos : 10'd0;
            r_out.position_valid  <= r_pvalid;
            r_out.sensor_flags    <= r_flags;
            r_out.battery_average <= r_bat_avg;
            r_out.battery_valid   <= r_bvalid;
            r_out.battery_low     <= (r_bat_avg < r_bat_low);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.position <= 10'd1000))
        else $error("position out of range");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.position_valid) |-> (o_out_data.position == 10'd0))
        else $error("position without valid");
`endif
endmodule

[test/tb_line_sensor_position_tracker.sv]
module tb_line_sensor_position_tracker;
    import lspt_pkg::*;

    localparam int          AVG_N      = AVG_COUNT_DEF;
    localparam int          BAT_N      = BAT_COUNT_DEF;
    localparam int          SHIFT      = COEF_SHIFT_DEF;
    localparam longint      SCALE_NUM  = 64'd1 << (NORM_BITS_DEF + COEF_SHIFT_DEF);
    localparam int unsigned WGT [NCH]  = '{166, 333, 500, 666, 833};
    localparam int          CYCLE_CAP  = 3000000;
    localparam int          HOLD_LEN   = 300;
    localparam int          SETTLE     = 250;
    localparam int          ITEMS_EACH = 475;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_data;

    line_sensor_position_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Mirror of the tracker state and registers.
    logic [14:0] sum_acc    [NCH];
    logic [3:0]  scan_cnt;
    logic [11:0] chan_avg   [NCH];
    logic [15:0] cal_lo     [NCH];
    logic [15:0] cal_hi     [NCH];
    logic [20:0] coef       [NCH];
    logic [4:0]  flags_q;
    logic [7:0]  lost_cnt;
    logic [9:0]  held_pos;
    logic [4:0]  held_flags;
    logic [17:0] bat_sum;
    logic [6:0]  bat_cnt;
    logic [11:0] bat_avg;
    logic [12:0] set_lvl;
    logic [12:0] clr_lvl;
    logic [7:0]  debounce_lvl;
    logic [11:0] bat_low_lvl;

    t_out_word   pending_words[$];
    int          mismatches;
    int          cycles;
    bit          hold_req;
    bit          no_idle;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word e;
    } t_row;
    t_row        directed_rows[$];

    // Clock and cycle limit.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [20:0] coef_from_span(logic [15:0] hi, logic [15:0] lo);
        longint q;
        if (hi == lo) return COEF_MAX;
        if (hi < lo) return '0;
        q = SCALE_NUM / longint'(hi - lo);
        return (q > longint'(COEF_MAX)) ? COEF_MAX : q[20:0];
    endfunction

    function automatic void tracker_reset();
        for (int i = 0; i < NCH; i++) begin
            sum_acc[i]  = '0;
            chan_avg[i] = '0;
            cal_lo[i]   = 16'd0;
            cal_hi[i]   = 16'hFFFF;
            coef[i]     = coef_from_span(16'hFFFF, 16'd0);
        end
        scan_cnt     = '0;
        flags_q      = '0;
        lost_cnt     = '0;
        held_pos     = '0;
        held_flags   = '0;
        bat_sum      = '0;
        bat_cnt      = '0;
        bat_avg      = '0;
        set_lvl      = 13'd2048;
        clr_lvl      = 13'd1024;
        debounce_lvl = 8'd10;
        bat_low_lvl  = 12'd0;
    endfunction

    // Closes an averaging window and returns the position.
    function automatic logic [9:0] close_window();
        int unsigned inv [NCH];
        int unsigned num;
        int unsigned den;
        int unsigned pos;
        longint      lin;
        logic [11:0] a;
        num = 0;
        den = 0;
        for (int i = 0; i < NCH; i++) begin
            a = 12'(sum_acc[i] / AVG_N);
            chan_avg[i] = a;
            sum_acc[i] = '0;
            lin = 0;
            if (a > cal_lo[i]) begin
                lin = (longint'(a - cal_lo[i]) * longint'(coef[i])) >>> SHIFT;
                if (lin > 4095) lin = 4095;
            end
            inv[i] = 4096 - int'(lin);
            num += WGT[i] * inv[i];
            den += inv[i];
        end
        pos = num / den;
        for (int i = 0; i < NCH; i++) begin
            if (inv[i] > set_lvl) flags_q[i] = 1'b1;
            else if (inv[i] < clr_lvl) flags_q[i] = 1'b0;
        end
        if (flags_q != 0) begin
            if (lost_cnt != 0) begin
                lost_cnt = '0;
            end else begin
                held_pos   = pos[9:0];
                held_flags = flags_q;
            end
        end else if (lost_cnt < debounce_lvl) begin
            lost_cnt++;
        end else if (held_pos >= 500) begin
            pos = held_flags[0] ? 1 : 1000;
        end else begin
            pos = held_flags[4] ? 1000 : 1;
        end
        return pos[9:0];
    endfunction

    function automatic t_out_word track_word(t_in_word w);
        t_out_word r;
        logic [11:0] s [NCH];
        r = '0;
        s = '{w.sample_0, w.sample_1, w.sample_2, w.sample_3, w.sample_4};
        case (w.func)
            FUNC_SCAN: begin
                for (int i = 0; i < NCH; i++) sum_acc[i] += s[i];
                scan_cnt++;
                if (scan_cnt >= AVG_N) begin
                    scan_cnt = '0;
                    r.position = close_window();
                    r.position_valid = 1'b1;
                end
                bat_sum += w.battery_sample;
                bat_cnt++;
                if (bat_cnt >= BAT_N) begin
                    bat_avg = 12'(bat_sum / BAT_N);
                    bat_sum = '0;
                    bat_cnt = '0;
                    r.battery_valid = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < NCH; i++) begin
                    cal_lo[i] = 16'hFFFF;
                    cal_hi[i] = 16'd0;
                end
            end
            FUNC_MINMAX: begin
                for (int i = 0; i < NCH; i++) begin
                    if (chan_avg[i] < cal_lo[i]) cal_lo[i] = chan_avg[i];
                    if (chan_avg[i] > cal_hi[i]) cal_hi[i] = chan_avg[i];
                end
            end
            default: begin
                for (int i = 0; i < NCH; i++) coef[i] = coef_from_span(cal_hi[i], cal_lo[i]);
            end
        endcase
        r.sensor_flags    = flags_q;
        r.battery_average = bat_avg;
        r.battery_low     = (bat_avg < bat_low_lvl);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one word and waits until it is taken.
    task automatic send_word(t_in_word w, bit typed, t_out_word e);
        t_out_word p;
        repeat (pick_gap()) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (o_in_stall);
        p = track_word(w);
        pending_words.push_back(typed ? e : p);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_in_data  = t_in_word'($urandom());
    endtask

    task automatic drain();
        wait (pending_words.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            REG_FLAG_SET:   set_lvl = val;
            REG_FLAG_CLEAR: clr_lvl = val;
            REG_DEBOUNCE:   debounce_lvl = val[7:0];
            default:        bat_low_lvl = val[11:0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_in_word make_word(logic [1:0] f, logic [11:0] s0, logic [11:0] s1,
                                           logic [11:0] s2, logic [11:0] s3,
                                           logic [11:0] s4, logic [11:0] b);
        t_in_word w;
        w.func = f;
        w.sample_0 = s0;
        w.sample_1 = s1;
        w.sample_2 = s2;
        w.sample_3 = s3;
        w.sample_4 = s4;
        w.battery_sample = b;
        return w;
    endfunction

    function automatic void add_row(t_in_word w, bit typed, t_out_word e);
        t_row r;
        r.w = w;
        r.typed = typed;
        r.e = e;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [11:0] near(int lvl);
        int v;
        if ($urandom_range(0, 9) == 0) return 12'($urandom());
        v = lvl + $urandom_range(0, 128) - 64;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    // Scan windows with a line profile, calibration runs and a little noise.
    task automatic random_phase(int n);
        int sent;
        int lvl [NCH];
        int bat_lvl;
        int r;
        t_out_word none;
        none = '0;
        sent = 0;
        bat_lvl = $urandom_range(0, 4095);
        while (sent < n) begin
            if ((sent / 100) % 4 == 3) no_idle = 1'b1;
            else no_idle = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_word(make_word(FUNC_CLEAR, 12'($urandom()), 12'($urandom()),
                                    12'($urandom()), 12'($urandom()), 12'($urandom()),
                                    12'($urandom())), 0, none);
                for (int k = 0; k < 2 * AVG_N; k++) begin
                    lvl[0] = (k < AVG_N) ? 300 : 3700;
                    send_word(make_word(FUNC_SCAN, near(lvl[0]), near(lvl[0]), near(lvl[0]),
                                        near(lvl[0]), near(lvl[0]), near(bat_lvl)), 0, none);
                    if (k % AVG_N == AVG_N - 1)
                        send_word(make_word(FUNC_MINMAX, 12'($urandom()), 12'($urandom()),
                                            12'($urandom()), 12'($urandom()),
                                            12'($urandom()), 12'($urandom())), 0, none);
                end
                send_word(make_word(FUNC_COEF, 12'($urandom()), 12'($urandom()),
                                    12'($urandom()), 12'($urandom()), 12'($urandom()),
                                    12'($urandom())), 0, none);
                sent += 2 * AVG_N + 4;
            end else if (r < 14) begin
                send_word(t_in_word'({$urandom(), $urandom(), $urandom()}), 0, none);
                sent++;
            end else begin
                for (int i = 0; i < NCH; i++) begin
                    r = $urandom_range(0, 9);
                    lvl[i] = (r < 3) ? $urandom_range(100, 700) :
                             (r < 8) ? $urandom_range(3000, 4000) : $urandom_range(0, 4095);
                end
                if ($urandom_range(0, 4) == 0)
                    for (int i = 0; i < NCH; i++) lvl[i] = $urandom_range(3400, 4095);
                if ($urandom_range(0, 19) == 0) bat_lvl = $urandom_range(0, 4095);
                for (int k = 0; k < AVG_N; k++)
                    send_word(make_word(FUNC_SCAN, near(lvl[0]), near(lvl[1]), near(lvl[2]),
                                        near(lvl[3]), near(lvl[4]), near(bat_lvl)), 0, none);
                sent += AVG_N;
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int stall_left;
        int r;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (no_idle) begin
                i_out_stall = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) stall_left = 0;
                else if (r < 96) stall_left = $urandom_range(1, 3);
                else stall_left = $urandom_range(10, 40);
                i_out_stall = (stall_left > 0);
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each taken result word with the oldest expected one.
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: result word with none expected, got %h", $time, o_out_data);
                mismatches++;
            end else begin
                e = pending_words.pop_front();
                check_field("position", e.position, o_out_data.position);
                check_field("position_valid", e.position_valid, o_out_data.position_valid);
                check_field("sensor_flags", e.sensor_flags, o_out_data.sensor_flags);
                check_field("battery_average", e.battery_average, o_out_data.battery_average);
                check_field("battery_valid", e.battery_valid, o_out_data.battery_valid);
                check_field("battery_low", e.battery_low, o_out_data.battery_low);
            end
        end
    end

    initial begin
        t_out_word zero_word;
        t_out_word full_window;
        mismatches = 0;
        cycles     = 0;
        hold_req   = 1'b0;
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_FLAG_SET;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        tracker_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: calibration corners, full-scale and zero scans.
        zero_word = '0;
        full_window = '0;
        full_window.position = 10'd499;
        full_window.position_valid = 1'b1;
        full_window.sensor_flags = 5'h1F;
        add_row(make_word(FUNC_CLEAR, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF),
                1, zero_word);
        // Minimum above maximum gives a zero coefficient.
        add_row(make_word(FUNC_COEF, 0, 0, 0, 0, 0, 0), 1, zero_word);
        for (int k = 0; k < AVG_N; k++)
            add_row(make_word(FUNC_SCAN, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                              12'hFFF), k == AVG_N - 1, full_window);
        // Equal minimum and maximum saturate the coefficient.
        add_row(make_word(FUNC_MINMAX, 0, 0, 0, 0, 0, 0), 0, zero_word);
        add_row(make_word(FUNC_COEF, 0, 0, 0, 0, 0, 0), 0, zero_word);
        for (int k = 0; k < AVG_N; k++)
            add_row(make_word(FUNC_SCAN, 0, 0, 0, 0, 0, 0), 0, zero_word);
        add_row(make_word(FUNC_MINMAX, 0, 0, 0, 0, 0, 0), 0, zero_word);
        add_row(make_word(FUNC_COEF, 0, 0, 0, 0, 0, 0), 0, zero_word);
        for (int k = 0; k < AVG_N; k++)
            add_row(make_word(FUNC_SCAN, 12'hFFF, 0, 12'h800, 12'h001, 12'hFFE, 12'h555),
                    0, zero_word);
        foreach (directed_rows[j])
            send_word(directed_rows[j].w, directed_rows[j].typed, directed_rows[j].e);
        drain();

        // Phase 1: default-like levels, long receiver hold-off at the start.
        cfg_write(REG_FLAG_SET, 13'd2048);
        cfg_write(REG_FLAG_CLEAR, 13'd1024);
        cfg_write(REG_DEBOUNCE, 13'd3);
        cfg_write(REG_BAT_LOW, 13'd2000);
        hold_req = 1'b1;
        random_phase(ITEMS_EACH);
        drain();

        // Phase 2: lower extremes, immediate edge forcing.
        cfg_write(REG_FLAG_SET, 13'd0);
        cfg_write(REG_FLAG_CLEAR, 13'd0);
        cfg_write(REG_DEBOUNCE, 13'd0);
        cfg_write(REG_BAT_LOW, 13'd4095);
        random_phase(ITEMS_EACH);
        drain();

        // Phase 3: upper extremes.
        cfg_write(REG_FLAG_SET, 13'd4096);
        cfg_write(REG_FLAG_CLEAR, 13'd4096);
        cfg_write(REG_DEBOUNCE, 13'd255);
        cfg_write(REG_BAT_LOW, 13'd0);
        random_phase(ITEMS_EACH);
        drain();

        // Phase 4: random levels.
        cfg_write(REG_FLAG_SET, 13'($urandom_range(1500, 3500)));
        cfg_write(REG_FLAG_CLEAR, 13'($urandom_range(200, 1500)));
        cfg_write(REG_DEBOUNCE, 13'($urandom_range(0, 6)));
        cfg_write(REG_BAT_LOW, 13'($urandom_range(0, 4095)));
        random_phase(ITEMS_EACH);
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
